/* design/bba_pkg.sv */
package bba_pkg;

    typedef enum logic [1:0] {
        FUNC_INIT    = 2'd0,
        FUNC_ALLOC   = 2'd1,
        FUNC_FREE    = 2'd2,
        FUNC_RESERVE = 2'd3
    } func_t;

    localparam int FUNC_W  = 2;
    localparam int BLOCK_W = 12;
    localparam int COUNT_W = 13;

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // latch request and effective total
        logic fill_word;   // write all ones to word at index
        logic scan_word;   // read word at index into scan register
        logic scan_bit;    // examine one bit of the scan register
        logic mark_bit;    // write one run bit
        logic read_zero;   // read word 0 into scan register
        logic force_zero;  // force block 0 used
        logic upd_count;   // update used count, build result
    } bba_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_alloc;
        logic is_init;
        logic is_free;
        logic bad_count;
        logic word_last;   // fill index at last word
        logic scan_end;    // search reached total
        logic bit_last;    // current scan bit is last of the word
        logic found;       // run found this step
        logic mark_done;   // run walk complete
    } bba_status_t;

endpackage

/* design/bba_if.sv */
interface bba_req_if;
    import bba_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [FUNC_W-1:0]    func;
    logic [BLOCK_W-1:0]   start_block;
    logic [COUNT_W-1:0]   count;
    modport source (output valid, func, start_block, count, input ready);
    modport sink (input valid, func, start_block, count, output ready);
endinterface

interface bba_rsp_if;
    import bba_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 ok;
    logic [BLOCK_W-1:0]   block;
    logic [COUNT_W-1:0]   used_count;
    logic [COUNT_W-1:0]   free_count;
    modport source (output valid, ok, block, used_count, free_count, input ready);
    modport sink (input valid, ok, block, used_count, free_count, output ready);
endinterface

interface bba_cfg_if;
    import bba_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [COUNT_W-1:0]   data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

/* design/bitmap_block_allocator_top.sv */
// Bitmap first-fit block allocator. One request is taken at a time; a new item is
// accepted only after the previous result has been taken. After reset the block marks
// every bitmap word used before it accepts the first item. Initialize fills every
// bitmap word; allocate scans the bitmap one bit per cycle (plus one word read per 32
// blocks) up to the effective total, then marks the run with a word read and a bit
// write per block; free and reserve walk each block of the run the same way (blocks
// beyond storage are skipped), and free then reads and rewrites word 0 to force block 0
// used. Each bit is handled through a read and a write of the bitmap memory. The user
// must write the total register only while idle; the block does not enforce it. The
// total is clamped and rounded down to whole 32-block words when a request is loaded.
module bitmap_block_allocator_top
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS = 4096,
    parameter int WORD_BITS  = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    bba_req_if.sink   req,
    bba_rsp_if.source rsp,
    bba_cfg_if.sink   cfg
);
    bba_cmd_t           cmd;
    bba_status_t        status;
    logic [COUNT_W-1:0] total_reg;

    // Hold configuration register
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            total_reg <= '0;
        else if (cfg.valid)
            total_reg <= cfg.data;
    end

    bba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .status    (status)
    );

    bba_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .WORD_BITS  (WORD_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .in_func      (req.func),
        .in_start     (req.start_block),
        .in_count     (req.count),
        .total_blocks (total_reg),
        .res_ok       (rsp.ok),
        .res_block    (rsp.block),
        .res_used     (rsp.used_count),
        .res_free     (rsp.free_count)
    );

endmodule

/* design/bba_datapath.sv */
module bba_datapath
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS = 4096,
    parameter int WORD_BITS  = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  bba_cmd_t             cmd,
    output bba_status_t          status,
    input  logic [FUNC_W-1:0]    in_func,
    input  logic [BLOCK_W-1:0]   in_start,
    input  logic [COUNT_W-1:0]   in_count,
    input  logic [COUNT_W-1:0]   total_blocks,
    output logic                 res_ok,
    output logic [BLOCK_W-1:0]   res_block,
    output logic [COUNT_W-1:0]   res_used,
    output logic [COUNT_W-1:0]   res_free
);
    localparam int NUM_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int WI_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BI_W = $clog2(WORD_BITS);
    localparam int B_W  = $clog2(MAX_BLOCKS) + 2;

    logic [WORD_BITS-1:0] mem [NUM_WORDS];

    logic [FUNC_W-1:0]    func_reg;
    logic [B_W-1:0]       start_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   total_reg;
    logic [COUNT_W-1:0]   used_reg;
    logic [B_W-1:0]       pos_reg;     // fill word index / scan block / mark block
    logic [COUNT_W-1:0]   run_reg;
    logic [B_W-1:0]       first_reg;
    logic [COUNT_W-1:0]   left_reg;
    logic [WORD_BITS-1:0] word_reg;
    logic                 found_reg;

    logic [COUNT_W-1:0]   eff_total;
    logic                 cur_used;
    logic [COUNT_W:0]     sum_used;

    // Clamp and round total down to whole words
    always_comb
    begin
        logic [COUNT_W-1:0] t;
        t = total_blocks;
        if (32'(t) > MAX_BLOCKS)
            t = COUNT_W'(MAX_BLOCKS);
        eff_total = (t / COUNT_W'(WORD_BITS)) * COUNT_W'(WORD_BITS);
    end

    assign cur_used = word_reg[pos_reg[BI_W-1:0]];
    assign sum_used = {1'b0, used_reg} + {1'b0, count_reg};

    always_comb
    begin
        status.is_alloc  = (func_reg == FUNC_ALLOC);
        status.is_init   = (func_reg == FUNC_INIT);
        status.is_free   = (func_reg == FUNC_FREE);
        status.bad_count = (count_reg == '0) || (count_reg >= total_reg);
        status.word_last = (pos_reg == B_W'(NUM_WORDS - 1));
        status.scan_end  = (pos_reg >= B_W'(total_reg));
        status.bit_last  = (pos_reg[BI_W-1:0] == BI_W'(WORD_BITS - 1));
        status.found     = !cur_used && (run_reg + 1'b1 == count_reg);
        status.mark_done = (left_reg == '0) || (pos_reg >= B_W'(MAX_BLOCKS));
    end

    // Request registers and walkers; index starts at zero for the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            func_reg  <= '0;
            start_reg <= '0;
            count_reg <= '0;
            total_reg <= '0;
            left_reg  <= '0;
            run_reg   <= '0;
            first_reg <= '0;
            found_reg <= 1'b0;
            pos_reg   <= '0;
            word_reg  <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                func_reg  <= in_func;
                start_reg <= B_W'(in_start);
                count_reg <= in_count;
                total_reg <= eff_total;
                left_reg  <= in_count;
                run_reg   <= '0;
                first_reg <= '0;
                found_reg <= 1'b0;
                pos_reg   <= (in_func == FUNC_INIT || in_func == FUNC_ALLOC) ? '0
                                                                        : B_W'(in_start);
            end
            else if (cmd.fill_word)
                pos_reg <= pos_reg + 1'b1;
            else if (cmd.scan_bit)
            begin
                if (cur_used)
                begin
                    run_reg   <= '0;
                    first_reg <= pos_reg + 1'b1;
                end
                else
                    run_reg <= run_reg + 1'b1;
                if (status.found)
                begin
                    found_reg <= 1'b1;
                    pos_reg   <= first_reg;
                end
                else
                    pos_reg <= pos_reg + 1'b1;
            end
            else if (cmd.mark_bit)
            begin
                pos_reg  <= pos_reg + 1'b1;
                left_reg <= left_reg - 1'b1;
            end
            if (cmd.scan_word)
                word_reg <= mem[pos_reg[BI_W+WI_W-1:BI_W]];
            else if (cmd.read_zero)
                word_reg <= mem[0];
        end
    end

    // Bitmap writes: word fills, and one read-modify-write of a word per mark step via scan register
    always_ff @(posedge clk)
    begin
        if (cmd.fill_word)
            mem[pos_reg[WI_W-1:0]] <= '1;
        else if (cmd.mark_bit)
        begin
            logic [WORD_BITS-1:0] w;
            w = word_reg;
            w[pos_reg[BI_W-1:0]] = !status.is_free;
            mem[pos_reg[BI_W+WI_W-1:BI_W]] <= w;
        end
        else if (cmd.force_zero)
        begin
            logic [WORD_BITS-1:0] w0;
            w0 = word_reg;
            w0[0] = 1'b1;
            mem[0] <= w0;
        end
    end

    // Used count and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            used_reg <= '0;
        else if (cmd.upd_count)
        begin
            if (status.is_init)
                used_reg <= total_reg;
            else if (status.is_free)
                used_reg <= (count_reg > used_reg) ? '0 : used_reg - count_reg;
            else if (!(status.is_alloc && !found_reg))
                used_reg <= (sum_used > {1'b0, total_reg}) ? total_reg
                                                           : sum_used[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.upd_count)
        begin
            res_ok    <= !(status.is_alloc && !found_reg);
            res_block <= (status.is_alloc && found_reg) ? BLOCK_W'(first_reg) : '0;
        end
    end

    assign res_used = used_reg;
    assign res_free = (used_reg > total_reg) ? '0 : total_reg - used_reg;

endmodule

/* design/bba_ctrl.sv */
module bba_ctrl
    import bba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output bba_cmd_t    cmd,
    input  bba_status_t status
);
    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_DECODE = 11'b00000000010,
        S_FILL   = 11'b00000000100,
        S_SRD    = 11'b00000001000,
        S_SBIT   = 11'b00000010000,
        S_MRD    = 11'b00000100000,
        S_MBIT   = 11'b00001000000,
        S_ZRD    = 11'b00010000000,
        S_ZWR    = 11'b00100000000,
        S_DONE   = 11'b01000000000,
        S_CLR    = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    // Accept a new item when idle and the output slot is free
    assign req_ready = (state_reg == S_IDLE) && !rsp_valid_reg;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        cmd            = '0;
        if (rsp_valid_reg && rsp_ready)
            rsp_valid_next = 1'b0;
        case (state_reg)
            S_CLR:
            begin
                // Mark every block used after reset
                cmd.fill_word = 1'b1;
                if (status.word_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (status.is_init)
                    state_next = S_FILL;
                else if (status.is_alloc)
                    state_next = status.bad_count ? S_DONE : S_SRD;
                else
                    state_next = S_MRD;
            end
            S_FILL:
            begin
                cmd.fill_word = 1'b1;
                if (status.word_last)
                    state_next = S_DONE;
            end
            S_SRD:
            begin
                if (status.scan_end)
                    state_next = S_DONE;
                else
                begin
                    cmd.scan_word = 1'b1;
                    state_next    = S_SBIT;
                end
            end
            S_SBIT:
            begin
                if (status.scan_end)
                    state_next = S_DONE;
                else
                begin
                    cmd.scan_bit = 1'b1;
                    if (status.found)
                        state_next = S_MRD;
                    else if (status.bit_last)
                        state_next = S_SRD;
                end
            end
            S_MRD:
            begin
                if (status.mark_done)
                    state_next = status.is_free ? S_ZRD : S_DONE;
                else
                begin
                    cmd.scan_word = 1'b1;
                    state_next    = S_MBIT;
                end
            end
            S_MBIT:
            begin
                cmd.mark_bit = 1'b1;
                state_next   = S_MRD;
            end
            S_ZRD:
            begin
                cmd.read_zero = 1'b1;
                state_next    = S_ZWR;
            end
            S_ZWR:
            begin
                cmd.force_zero = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                cmd.upd_count  = 1'b1;
                rsp_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Result raised after done, no accept while busy, one bitmap command at a time
    a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE |=> rsp_valid_reg)
        else $error("result not raised after done");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !req_ready)
        else $error("accepting while busy");
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.fill_word, cmd.scan_bit, cmd.mark_bit, cmd.force_zero}) <= 1)
        else $error("conflicting bitmap commands");

endmodule
